[src/ttes_pkg.sv]
// Types and codes for the timer table with expiry scan.
// No dependencies; imported by every module of the block.
package ttes_pkg;

  localparam logic [47:0] DL_MAX = 48'hFFFF_FFFF_FFFF;

  typedef enum logic [1:0] {
    ACT_CREATE = 2'd0,
    ACT_STOP   = 2'd1,
    ACT_SCAN   = 2'd2,
    ACT_APPLY  = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    KIND_CREATED = 3'd0,
    KIND_STOPPED = 3'd1,
    KIND_SCAN    = 3'd2,
    KIND_APPLIED = 3'd3,
    KIND_FULL    = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DONE
  } state_e;

  typedef struct packed {
    action_e     action;
    logic [47:0] now;
    logic [31:0] delay;
    logic [15:0] handler;
    logic [7:0]  event_type;
    logic [31:0] timer_id;
  } in_t;

  typedef struct packed {
    kind_e       result_kind;
    logic        found;
    logic [31:0] out_id;
    logic        fire;
    logic [15:0] fire_handler;
    logic [7:0]  fire_type;
    logic [47:0] nearest_deadline;
    logic        last;
  } out_t;

  typedef struct packed {
    logic [31:0] id;
    logic [47:0] deadline;
    logic [15:0] handler;
    logic [7:0]  etype;
  } entry_t;

  typedef struct packed {
    logic ent_we;
    logic canc_we;
    logic canc_val;
    logic vld_set;
    logic vld_clr;
  } wr_ctl_t;

endpackage

[src/ttes_store.sv]
// Slot storage: entry and cancel-flag memories plus per-slot valid flops.
// Depends on ttes_pkg. One write port, one registered read port.
module ttes_store #(
  parameter int TABLE_SLOTS = 16,
  parameter int IdxW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [IdxW-1:0]   rd_addr_i,
  output ttes_pkg::entry_t  rd_ent_o,
  output logic              rd_canc_o,
  output logic              rd_vld_o,
  input  ttes_pkg::wr_ctl_t wr_ctl_i,
  input  logic [IdxW-1:0]   wr_addr_i,
  input  ttes_pkg::entry_t  wr_ent_i
);
  import ttes_pkg::*;

  entry_t           ent_mem [TABLE_SLOTS];
  logic             canc_mem [TABLE_SLOTS];
  logic [TABLE_SLOTS-1:0] valid_q;
  entry_t           rd_ent_q;
  logic             rd_canc_q;
  logic             rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (wr_ctl_i.ent_we) begin
      ent_mem[wr_addr_i] <= wr_ent_i;
    end
    if (wr_ctl_i.canc_we) begin
      canc_mem[wr_addr_i] <= wr_ctl_i.canc_val;
    end
    rd_ent_q  <= ent_mem[rd_addr_i];
    rd_canc_q <= canc_mem[rd_addr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_ctl_i.vld_set) begin
        valid_q[wr_addr_i] <= 1'b1;
      end else if (wr_ctl_i.vld_clr) begin
        valid_q[wr_addr_i] <= 1'b0;
      end
      rd_vld_q <= valid_q[rd_addr_i];
    end
  end

  assign rd_ent_o  = rd_ent_q;
  assign rd_canc_o = rd_canc_q;
  assign rd_vld_o  = rd_vld_q;

endmodule

[src/ttes_ctrl.sv]
// Sequencer: walks the slots one per cycle through a shared compare unit
// (scans stall on a full output), then commits the table update and holds
// results in an output register. Depends on ttes_pkg; drives ttes_store.
module ttes_ctrl #(
  parameter int TABLE_SLOTS = 16,
  parameter int IdxW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  ttes_pkg::in_t     in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output ttes_pkg::out_t    out_data_o,
  output logic [IdxW-1:0]   rd_addr_o,
  input  ttes_pkg::entry_t  rd_ent_i,
  input  logic              rd_canc_i,
  input  logic              rd_vld_i,
  output ttes_pkg::wr_ctl_t wr_ctl_o,
  output logic [IdxW-1:0]   wr_addr_o,
  output ttes_pkg::entry_t  wr_ent_o
);
  import ttes_pkg::*;

  localparam logic [IdxW-1:0] LastIdx = IdxW'(TABLE_SLOTS - 1);

  state_e          state_q, state_d;
  in_t             cmd_q, cmd_d;
  logic [31:0]     key_q, key_d;
  logic [31:0]     cnt_q, cnt_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic            hit_q, hit_d;
  logic [IdxW-1:0] hit_idx_q, hit_idx_d;
  logic            hit_canc_q, hit_canc_d;
  logic [15:0]     hit_hnd_q, hit_hnd_d;
  logic [7:0]      hit_type_q, hit_type_d;
  logic            free_q, free_d;
  logic [IdxW-1:0] free_idx_q, free_idx_d;
  logic            pend_q, pend_d;
  logic [31:0]     pend_id_q, pend_id_d;
  logic            have_q, have_d;
  logic [47:0]     near_q, near_d;
  logic            out_vld_q, out_vld_d;
  out_t            out_q, out_d;

  logic        in_acc, out_free, is_scan, at_end;
  logic        id_hit, expired, walk_stall, walk_exit;
  logic [48:0] dl_sum;
  logic [47:0] dl_sat;

  assign in_acc     = in_valid_i && in_ready_o;
  assign out_free   = !out_vld_q || out_ready_i;
  assign is_scan    = (cmd_q.action == ACT_SCAN);
  assign at_end     = (idx_q == LastIdx);
  assign id_hit     = rd_vld_i && (rd_ent_i.id == key_q);
  assign expired    = rd_vld_i && ((cmd_q.now >= rd_ent_i.deadline) || rd_canc_i);
  assign walk_stall = is_scan && expired && pend_q && !out_free;
  assign walk_exit  = !walk_stall && (at_end || (!is_scan && id_hit));
  assign dl_sum     = {1'b0, cmd_q.now} + {17'b0, cmd_q.delay};
  assign dl_sat     = dl_sum[48] ? DL_MAX : dl_sum[47:0];

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_acc) state_d = ST_WALK;
      ST_WALK: if (walk_exit) state_d = ST_DONE;
      ST_DONE: if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_d      = cmd_q;
    key_d      = key_q;
    cnt_d      = cnt_q;
    idx_d      = '0;
    hit_d      = hit_q;
    hit_idx_d  = hit_idx_q;
    hit_canc_d = hit_canc_q;
    hit_hnd_d  = hit_hnd_q;
    hit_type_d = hit_type_q;
    free_d     = free_q;
    free_idx_d = free_idx_q;
    pend_d     = pend_q;
    pend_id_d  = pend_id_q;
    have_d     = have_q;
    near_d     = near_q;
    out_d      = out_q;
    out_vld_d  = out_vld_q && !out_ready_i;
    wr_ctl_o   = '0;
    wr_addr_o  = hit_idx_q;
    wr_ent_o   = '{id: key_q, deadline: dl_sat, handler: cmd_q.handler,
                   etype: cmd_q.event_type};
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          cmd_d  = in_data_i;
          key_d  = (in_data_i.action == ACT_CREATE) ? cnt_q + 32'd1 : in_data_i.timer_id;
          hit_d  = 1'b0;
          free_d = 1'b0;
          pend_d = 1'b0;
          have_d = 1'b0;
          near_d = '0;
        end
      end
      ST_WALK: begin
        if (walk_stall || walk_exit) begin
          idx_d = idx_q;
        end else begin
          idx_d = idx_q + 1'b1;
        end
        if (!walk_stall) begin
          if (!is_scan) begin
            if (id_hit) begin
              hit_d      = 1'b1;
              hit_idx_d  = idx_q;
              hit_canc_d = rd_canc_i;
              hit_hnd_d  = rd_ent_i.handler;
              hit_type_d = rd_ent_i.etype;
            end
            if (!rd_vld_i && !free_q) begin
              free_d     = 1'b1;
              free_idx_d = idx_q;
            end
          end else if (expired) begin
            pend_d    = 1'b1;
            pend_id_d = rd_ent_i.id;
            if (pend_q) begin
              out_d             = '0;
              out_d.result_kind = KIND_SCAN;
              out_d.found       = 1'b1;
              out_d.out_id      = pend_id_q;
              out_vld_d         = 1'b1;
            end
          end else if (rd_vld_i && (!have_q || rd_ent_i.deadline < near_q)) begin
            near_d = rd_ent_i.deadline;
            have_d = 1'b1;
          end
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_vld_d  = 1'b1;
          out_d      = '0;
          out_d.last = 1'b1;
          case (cmd_q.action)
            ACT_CREATE: begin
              if (hit_q || free_q) begin
                wr_addr_o        = hit_q ? hit_idx_q : free_idx_q;
                wr_ctl_o.ent_we  = 1'b1;
                wr_ctl_o.canc_we = 1'b1;
                wr_ctl_o.vld_set = 1'b1;
                cnt_d            = key_q;
                out_d.result_kind = KIND_CREATED;
                out_d.out_id      = key_q;
              end else begin
                out_d.result_kind = KIND_FULL;
              end
            end
            ACT_STOP: begin
              wr_ctl_o.canc_we  = hit_q;
              wr_ctl_o.canc_val = 1'b1;
              out_d.result_kind = KIND_STOPPED;
              out_d.found       = hit_q;
            end
            ACT_SCAN: begin
              out_d.result_kind      = KIND_SCAN;
              out_d.found            = pend_q;
              out_d.out_id           = pend_q ? pend_id_q : 32'd0;
              out_d.nearest_deadline = near_q;
            end
            ACT_APPLY: begin
              wr_ctl_o.vld_clr  = hit_q;
              out_d.result_kind = KIND_APPLIED;
              out_d.found       = hit_q;
              if (hit_q && !hit_canc_q) begin
                out_d.fire         = 1'b1;
                out_d.fire_handler = hit_hnd_q;
                out_d.fire_type    = hit_type_q;
              end
            end
            default: out_d.result_kind = KIND_FULL;
          endcase
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      idx_q     <= '0;
      out_vld_q <= 1'b0;
      hit_q     <= 1'b0;
      free_q    <= 1'b0;
      pend_q    <= 1'b0;
      have_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      idx_q     <= idx_d;
      out_vld_q <= out_vld_d;
      hit_q     <= hit_d;
      free_q    <= free_d;
      pend_q    <= pend_d;
      have_q    <= have_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    key_q      <= key_d;
    hit_idx_q  <= hit_idx_d;
    hit_canc_q <= hit_canc_d;
    hit_hnd_q  <= hit_hnd_d;
    hit_type_q <= hit_type_d;
    free_idx_q <= free_idx_d;
    pend_id_q  <= pend_id_d;
    near_q     <= near_d;
    out_q      <= out_d;
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign rd_addr_o   = idx_d;
  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

[src/timer_table_with_expiry_scan_core.sv]
// Timer table with expiry scan. Each transaction walks the slots one per
// cycle through a single compare unit, stretched for scans by output
// back-pressure: an item is accepted, walks the slots (lookups stop early
// on a match) and is committed before the next item is taken.
// Reset clears the valid bits and the id counter at once; no clearing pass.
// Depends on ttes_pkg, ttes_store and ttes_ctrl.
module timer_table_with_expiry_scan_core #(
  parameter int TABLE_SLOTS = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  ttes_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output ttes_pkg::out_t out_data_o
);
  import ttes_pkg::*;

  localparam int IdxW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;

  logic [IdxW-1:0] rd_addr;
  entry_t          rd_ent;
  logic            rd_canc;
  logic            rd_vld;
  wr_ctl_t         wr_ctl;
  logic [IdxW-1:0] wr_addr;
  entry_t          wr_ent;

  ttes_store #(
    .TABLE_SLOTS(TABLE_SLOTS),
    .IdxW       (IdxW)
  ) u_store (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_addr_i(rd_addr),
    .rd_ent_o (rd_ent),
    .rd_canc_o(rd_canc),
    .rd_vld_o (rd_vld),
    .wr_ctl_i (wr_ctl),
    .wr_addr_i(wr_addr),
    .wr_ent_i (wr_ent)
  );

  ttes_ctrl #(
    .TABLE_SLOTS(TABLE_SLOTS),
    .IdxW       (IdxW)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .rd_addr_o  (rd_addr),
    .rd_ent_i   (rd_ent),
    .rd_canc_i  (rd_canc),
    .rd_vld_i   (rd_vld),
    .wr_ctl_o   (wr_ctl),
    .wr_addr_o  (wr_addr),
    .wr_ent_o   (wr_ent)
  );

  a_no_write_when_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_ctl.ent_we || wr_ctl.canc_we || wr_ctl.vld_set || wr_ctl.vld_clr) |-> !in_ready_o)
    else $error("table written while accepting input");

  a_ready_after_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_ctl.ent_we || wr_ctl.canc_we || wr_ctl.vld_clr) |=> in_ready_o)
    else $error("not ready after table commit");

  a_commit_with_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_ctl.ent_we || wr_ctl.canc_we || wr_ctl.vld_clr) |=> (out_valid_o && out_data_o.last))
    else $error("table commit without final result");

  a_create_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_ctl.ent_we |-> (wr_ctl.vld_set && !wr_ctl.vld_clr && wr_ctl.canc_we))
    else $error("entry write without valid set");

endmodule

[tb/tb_timer_table_with_expiry_scan_core.sv]
// Testbench for timer_table_with_expiry_scan_core: directed table, then random actions,
// each result checked in order against its pinned result or a behavioral timer table kept
// in the bench. Depends on ttes_pkg and the core RTL; self-contained otherwise.
module tb_timer_table_with_expiry_scan_core;
  timeunit 1ns;
  timeprecision 1ps;
  import ttes_pkg::*;

  localparam int SLOTS = 16;
  localparam int LONG_HOLD = 300;
  localparam int DRAIN_CYCLES = 40;

  typedef struct {
    in_t  item;
    int   reps;
    bit   pinned;
    out_t result;
  } row_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_t  in_data;
  logic out_valid;
  logic out_ready;
  out_t out_data;

  logic        tmr_valid     [SLOTS];
  logic [31:0] tmr_id        [SLOTS];
  logic [47:0] tmr_deadline  [SLOTS];
  logic [15:0] tmr_handler   [SLOTS];
  logic [7:0]  tmr_type      [SLOTS];
  logic        tmr_cancelled [SLOTS];
  logic [31:0] tmr_seq;

  out_t action_results[$];
  out_t pending_results[$];
  row_t directed_rows[$];
  bit   pinned_on;
  out_t pinned_result;
  bit   quiet;
  bit   hold_req;
  int   mismatches;

  timer_table_with_expiry_scan_core #(
    .TABLE_SLOTS(SLOTS)
  ) i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  function automatic int find_timer(logic [31:0] id);
    int i;
    for (i = 0; i < SLOTS; i++) begin
      if (tmr_valid[i] && tmr_id[i] == id) return i;
    end
    return -1;
  endfunction

  function automatic out_t make_result(kind_e kind, logic found, logic [31:0] id);
    out_t r;
    r = '0;
    r.result_kind = kind;
    r.found = found;
    r.out_id = id;
    r.last = 1'b1;
    return r;
  endfunction

  function automatic in_t mk_in(action_e a, logic [47:0] now, logic [31:0] delay,
                                logic [15:0] hnd, logic [7:0] et, logic [31:0] tid);
    in_t it;
    it.action = a;
    it.now = now;
    it.delay = delay;
    it.handler = hnd;
    it.event_type = et;
    it.timer_id = tid;
    return it;
  endfunction

  function automatic void add_row(in_t it, int reps, bit pinned, out_t res);
    row_t row;
    row.item = it;
    row.reps = reps;
    row.pinned = pinned;
    row.result = res;
    directed_rows = {directed_rows, row};
  endfunction

  // Updates the bench copy of the table and leaves the results in action_results.
  function automatic void apply_timer_action(in_t it);
    int s;
    int i;
    logic [31:0] nid;
    logic [48:0] sum;
    logic [47:0] nearest;
    bit have;
    out_t r;
    action_results.delete();
    case (it.action)
      ACT_CREATE: begin
        nid = tmr_seq + 32'd1;
        s = find_timer(nid);
        if (s < 0) begin
          for (i = SLOTS - 1; i >= 0; i--) begin
            if (!tmr_valid[i]) s = i;
          end
        end
        if (s < 0) begin
          action_results = {action_results, make_result(KIND_FULL, 1'b0, '0)};
        end else begin
          tmr_seq = nid;
          sum = {1'b0, it.now} + {17'd0, it.delay};
          tmr_valid[s] = 1'b1;
          tmr_id[s] = nid;
          tmr_deadline[s] = sum[48] ? DL_MAX : sum[47:0];
          tmr_handler[s] = it.handler;
          tmr_type[s] = it.event_type;
          tmr_cancelled[s] = 1'b0;
          action_results = {action_results, make_result(KIND_CREATED, 1'b0, nid)};
        end
      end
      ACT_STOP: begin
        s = find_timer(it.timer_id);
        if (s >= 0) tmr_cancelled[s] = 1'b1;
        action_results = {action_results, make_result(KIND_STOPPED, s >= 0, '0)};
      end
      ACT_SCAN: begin
        nearest = '0;
        have = 1'b0;
        for (i = 0; i < SLOTS; i++) begin
          if (tmr_valid[i]) begin
            if (it.now >= tmr_deadline[i] || tmr_cancelled[i]) begin
              r = make_result(KIND_SCAN, 1'b1, tmr_id[i]);
              r.last = 1'b0;
              action_results = {action_results, r};
            end else if (!have || tmr_deadline[i] < nearest) begin
              nearest = tmr_deadline[i];
              have = 1'b1;
            end
          end
        end
        if (action_results.size() == 0) begin
          r = make_result(KIND_SCAN, 1'b0, '0);
        end else begin
          r = action_results.pop_back();
          r.last = 1'b1;
        end
        r.nearest_deadline = nearest;
        action_results = {action_results, r};
      end
      default: begin
        s = find_timer(it.timer_id);
        if (s < 0) begin
          action_results = {action_results, make_result(KIND_APPLIED, 1'b0, '0)};
        end else begin
          tmr_valid[s] = 1'b0;
          r = make_result(KIND_APPLIED, 1'b1, '0);
          if (!tmr_cancelled[s]) begin
            r.fire = 1'b1;
            r.fire_handler = tmr_handler[s];
            r.fire_type = tmr_type[s];
          end
          action_results = {action_results, r};
        end
      end
    endcase
  endfunction

  // Mostly a live id; otherwise a recently used or arbitrary one.
  function automatic logic [31:0] pick_timer_id();
    int live[$];
    int i;
    for (i = 0; i < SLOTS; i++) begin
      if (tmr_valid[i]) live = {live, i};
    end
    if (live.size() == 0 || $urandom_range(0, 4) == 0) begin
      if ($urandom_range(0, 4) == 0) return $urandom;
      return tmr_seq - $urandom_range(0, 3);
    end
    return tmr_id[live[$urandom_range(0, live.size() - 1)]];
  endfunction

  function automatic int next_gap();
    if (!quiet && $urandom_range(0, 3) == 0) return $urandom_range(1, 17);
    return 0;
  endfunction

  task automatic send_item(in_t it, int gap);
    bit taken;
    in_valid <= 1'b1;
    in_data <= it;
    do begin
      @(negedge clk);
      taken = in_ready;
      @(posedge clk);
    end while (!taken);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic report_mismatch(string what, out_t want, out_t seen);
    mismatches++;
    if (mismatches <= 10) $display("%0t: %s: expected %p, got %p", $time, what, want, seen);
  endtask

  // Handshake values are stable at the falling edge; the transaction lands at the next rise.
  always @(negedge clk) begin : track_in
    if (rst_n && in_valid && in_ready) begin
      apply_timer_action(in_data);
      if (pinned_on) begin
        pending_results = {pending_results, pinned_result};
      end else begin
        foreach (action_results[k]) pending_results = {pending_results, action_results[k]};
      end
    end
  end

  always @(negedge clk) begin : check_out
    out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing pending", '0, out_data);
      end else begin
        want = pending_results.pop_front();
        if (out_data.result_kind !== want.result_kind || out_data.found !== want.found ||
            out_data.out_id !== want.out_id || out_data.fire !== want.fire ||
            out_data.fire_handler !== want.fire_handler ||
            out_data.fire_type !== want.fire_type ||
            out_data.nearest_deadline !== want.nearest_deadline ||
            out_data.last !== want.last) begin
          report_mismatch("result mismatch", want, out_data);
        end
      end
    end
  end

  initial begin : receiver
    int cyc;
    bit idle_on;
    out_ready = 1'b0;
    idle_on = 1'b1;
    cyc = 0;
    forever begin
      @(posedge clk);
      cyc++;
      if (cyc % 100 == 0) idle_on = $urandom_range(0, 2) != 0;
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (LONG_HOLD - 1) @(posedge clk);
      end else if (!quiet && idle_on && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(0, 16)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    #6_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin : stimulus
    in_t it;
    out_t r;
    int n;
    int k;
    int row;
    int pick;
    logic [47:0] wall;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    pinned_on = 1'b0;
    pinned_result = '0;
    quiet = 1'b0;
    hold_req = 1'b0;
    mismatches = 0;
    tmr_seq = '0;
    foreach (tmr_valid[i]) tmr_valid[i] = 1'b0;

    add_row(mk_in(ACT_SCAN, '0, '0, '0, '0, '0), 1, 1, make_result(KIND_SCAN, 1'b0, '0));
    add_row(mk_in(ACT_STOP, '0, '0, '0, '0, '0), 1, 1, make_result(KIND_STOPPED, 1'b0, '0));
    add_row(mk_in(ACT_APPLY, DL_MAX, '1, '1, '1, '1), 1, 1,
            make_result(KIND_APPLIED, 1'b0, '0));
    add_row(mk_in(ACT_CREATE, '0, '0, '1, '1, '0), 1, 1,
            make_result(KIND_CREATED, 1'b0, 32'd1));
    add_row(mk_in(ACT_CREATE, DL_MAX, '1, '0, '0, '1), 1, 1,
            make_result(KIND_CREATED, 1'b0, 32'd2));
    add_row(mk_in(ACT_CREATE, 48'd100, 32'd50, 16'h1234, 8'h5a, '0), 1, 1,
            make_result(KIND_CREATED, 1'b0, 32'd3));
    add_row(mk_in(ACT_STOP, '0, '0, '0, '0, 32'd2), 1, 1,
            make_result(KIND_STOPPED, 1'b1, '0));
    add_row(mk_in(ACT_SCAN, 48'd100, '0, '0, '0, '0), 1, 0, '0);
    r = make_result(KIND_APPLIED, 1'b1, '0);
    r.fire = 1'b1;
    r.fire_handler = '1;
    r.fire_type = '1;
    add_row(mk_in(ACT_APPLY, '0, '0, '0, '0, 32'd1), 1, 1, r);
    add_row(mk_in(ACT_APPLY, '0, '0, '0, '0, 32'd2), 1, 1,
            make_result(KIND_APPLIED, 1'b1, '0));
    add_row(mk_in(ACT_APPLY, '0, '0, '0, '0, 32'd2), 1, 1,
            make_result(KIND_APPLIED, 1'b0, '0));
    add_row(mk_in(ACT_CREATE, 48'd1000, 32'd100, '0, '0, '0), 14, 0, '0);
    add_row(mk_in(ACT_CREATE, 48'd1000, 32'd7, 16'hbeef, 8'h11, '0), 1, 1,
            make_result(KIND_CREATED, 1'b0, 32'd18));
    add_row(mk_in(ACT_CREATE, 48'd1000, 32'd7, 16'hbeef, 8'h11, '0), 1, 1,
            make_result(KIND_FULL, 1'b0, '0));
    r = make_result(KIND_SCAN, 1'b0, '0);
    r.nearest_deadline = 48'd150;
    add_row(mk_in(ACT_SCAN, '0, '0, '0, '0, '0), 1, 1, r);
    add_row(mk_in(ACT_SCAN, DL_MAX, '0, '0, '0, '0), 1, 0, '0);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (row = 0; row < directed_rows.size(); row++) begin
      for (k = 0; k < directed_rows[row].reps; k++) begin
        it = directed_rows[row].item;
        if (directed_rows[row].reps > 1) begin
          it.handler = 16'($urandom);
          it.event_type = 8'($urandom);
          it.delay = $urandom_range(100, 5000);
        end
        pinned_on = directed_rows[row].pinned;
        pinned_result = directed_rows[row].result;
        send_item(it, next_gap());
        pinned_on = 1'b0;
      end
    end

    wall = 48'd10000;
    for (n = 0; n < 91; n++) begin
      if (n == 30) hold_req = 1'b1;
      if (n == 57) begin
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0) @(posedge clk);
      end
      if (n == 72) quiet = 1'b1;
      wall += $urandom_range(0, 60);
      it.now = {16'($urandom), $urandom};
      it.delay = $urandom;
      it.handler = 16'($urandom);
      it.event_type = 8'($urandom);
      it.timer_id = $urandom;
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        it.action = ACT_CREATE;
        if ($urandom_range(0, 15) != 0) it.now = wall;
        if ($urandom_range(0, 7) != 0) it.delay = $urandom_range(0, 400);
      end else if (pick < 50) begin
        it.action = ACT_STOP;
        it.timer_id = pick_timer_id();
      end else if (pick < 70) begin
        it.action = ACT_SCAN;
        if ($urandom_range(0, 9) != 0) it.now = wall;
      end else begin
        it.action = ACT_APPLY;
        it.timer_id = pick_timer_id();
      end
      send_item(it, next_gap());
    end
    in_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
